### hdl/rmd160_pkg.sv
package rmd160_pkg;

  typedef struct packed {
    logic [63:0] msg_bytes_24_31;
    logic [63:0] msg_bytes_16_23;
    logic [63:0] msg_bytes_8_15;
    logic [63:0] msg_bytes_0_7;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_bytes_16_19;
    logic [63:0] digest_bytes_8_15;
    logic [63:0] digest_bytes_0_7;
  } digest_t;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] block_t;

  // Working variables of one line: a, b, c, d, e.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } line_t;

  // Everything that travels down the pipeline with one item.
  typedef struct packed {
    block_t w;
    line_t  lft;
    line_t  rgt;
  } stage_t;

  localparam int NumSteps = 80;

  localparam word_t Iv0 = 32'h67452301;
  localparam word_t Iv1 = 32'hEFCDAB89;
  localparam word_t Iv2 = 32'h98BADCFE;
  localparam word_t Iv3 = 32'h10325476;
  localparam word_t Iv4 = 32'hC3D2E1F0;
  localparam word_t PadWord = 32'h00000080;
  localparam word_t LenWord = 32'h00000100;

  localparam logic [3:0] WordLeft [NumSteps] = '{
    4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15,
    4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,4'd8,
    4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,4'd12,
    4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,4'd2,
    4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,4'd15,4'd13
  };
  localparam logic [3:0] WordRight [NumSteps] = '{
    4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,4'd12,
    4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,4'd2,
    4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,4'd13,
    4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,4'd14,
    4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,4'd9,4'd11
  };
  localparam logic [4:0] RotLeft [NumSteps] = '{
    5'd11,5'd14,5'd15,5'd12,5'd5,5'd8,5'd7,5'd9,5'd11,5'd13,5'd14,5'd15,5'd6,5'd7,5'd9,5'd8,
    5'd7,5'd6,5'd8,5'd13,5'd11,5'd9,5'd7,5'd15,5'd7,5'd12,5'd15,5'd9,5'd11,5'd7,5'd13,5'd12,
    5'd11,5'd13,5'd6,5'd7,5'd14,5'd9,5'd13,5'd15,5'd14,5'd8,5'd13,5'd6,5'd5,5'd12,5'd7,5'd5,
    5'd11,5'd12,5'd14,5'd15,5'd14,5'd15,5'd9,5'd8,5'd9,5'd14,5'd5,5'd6,5'd8,5'd6,5'd5,5'd12,
    5'd9,5'd15,5'd5,5'd11,5'd6,5'd8,5'd13,5'd12,5'd5,5'd12,5'd13,5'd14,5'd11,5'd8,5'd5,5'd6
  };
  localparam logic [4:0] RotRight [NumSteps] = '{
    5'd8,5'd9,5'd9,5'd11,5'd13,5'd15,5'd15,5'd5,5'd7,5'd7,5'd8,5'd11,5'd14,5'd14,5'd12,5'd6,
    5'd9,5'd13,5'd15,5'd7,5'd12,5'd8,5'd9,5'd11,5'd7,5'd7,5'd12,5'd7,5'd6,5'd15,5'd13,5'd11,
    5'd9,5'd7,5'd15,5'd11,5'd8,5'd6,5'd6,5'd14,5'd12,5'd13,5'd5,5'd14,5'd13,5'd13,5'd7,5'd5,
    5'd15,5'd5,5'd8,5'd11,5'd14,5'd14,5'd6,5'd14,5'd6,5'd9,5'd12,5'd9,5'd12,5'd5,5'd15,5'd8,
    5'd8,5'd5,5'd12,5'd9,5'd12,5'd5,5'd14,5'd6,5'd8,5'd13,5'd6,5'd5,5'd15,5'd13,5'd11,5'd11
  };
  localparam word_t AddLeft [5] = '{
    32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E
  };
  localparam word_t AddRight [5] = '{
    32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000
  };

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  function automatic word_t mix(input logic [2:0] g, input word_t x, input word_t y,
                                input word_t z);
    word_t r;
    case (g)
      3'd0: r = x ^ y ^ z;
      3'd1: r = (x & y) | (~x & z);
      3'd2: r = (x | ~y) ^ z;
      3'd3: r = (x & z) | (y & ~z);
      default: r = x ^ (y | ~z);
    endcase
    return r;
  endfunction

endpackage

### hdl/rmd160_step.sv
// One step of both lines, registered. The step number is tied to a constant per instance.
module rmd160_step import rmd160_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [6:0] step_idx,
  input  logic       adv,
  input  logic       in_valid,
  input  stage_t     in_data,
  output logic       out_valid,
  output stage_t     out_data
);

  logic [2:0] grp;
  stage_t nxt;
  word_t tl, tr;

  // Sixteen steps per round group.
  assign grp = step_idx[6:4];

  always_comb begin
    tl = rotl(in_data.lft.a + mix(grp, in_data.lft.b, in_data.lft.c, in_data.lft.d)
              + in_data.w[WordLeft[step_idx]] + AddLeft[grp], RotLeft[step_idx])
         + in_data.lft.e;
    tr = rotl(in_data.rgt.a + mix(3'd4 - grp, in_data.rgt.b, in_data.rgt.c, in_data.rgt.d)
              + in_data.w[WordRight[step_idx]] + AddRight[grp], RotRight[step_idx])
         + in_data.rgt.e;
    nxt.w = in_data.w;
    nxt.lft.a = in_data.lft.e;
    nxt.lft.e = in_data.lft.d;
    nxt.lft.d = rotl(in_data.lft.c, 5'd10);
    nxt.lft.c = in_data.lft.b;
    nxt.lft.b = tl;
    nxt.rgt.a = in_data.rgt.e;
    nxt.rgt.e = in_data.rgt.d;
    nxt.rgt.d = rotl(in_data.rgt.c, 5'd10);
    nxt.rgt.c = in_data.rgt.b;
    nxt.rgt.b = tr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= nxt;
    end
  end

endmodule

### hdl/ripemd160_hash_32byte.sv
// Channel | Signals                  | Payload
// in      | in_valid / in_ready      | msg_t (32 message bytes)
// out     | out_valid / out_ready    | digest_t (20 digest bytes)
//
// The block is an 80-stage pipeline, one register stage per step of the two
// parallel lines, plus an output register after the final cross-addition.
// It accepts one item every cycle while the output is not stalled; each digest
// passes through the step registers and then the output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall at the output freezes every stage in place.
// Synchronous reset clears all valid bits; data registers are not reset.
module ripemd160_hash_32byte import rmd160_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  msg_t    in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output digest_t out_data
);

  logic   adv;
  logic   vld [NumSteps+1];
  stage_t dat [NumSteps+1];
  word_t  h0, h1, h2, h3, h4;
  stage_t fin;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Pack the message little-endian into words and add the fixed padding.
  always_comb begin
    dat[0].w = '0;
    dat[0].w[0] = in_data.msg_bytes_0_7[31:0];
    dat[0].w[1] = in_data.msg_bytes_0_7[63:32];
    dat[0].w[2] = in_data.msg_bytes_8_15[31:0];
    dat[0].w[3] = in_data.msg_bytes_8_15[63:32];
    dat[0].w[4] = in_data.msg_bytes_16_23[31:0];
    dat[0].w[5] = in_data.msg_bytes_16_23[63:32];
    dat[0].w[6] = in_data.msg_bytes_24_31[31:0];
    dat[0].w[7] = in_data.msg_bytes_24_31[63:32];
    dat[0].w[8] = PadWord;
    dat[0].w[14] = LenWord;
    dat[0].lft = '{a: Iv0, b: Iv1, c: Iv2, d: Iv3, e: Iv4};
    dat[0].rgt = '{a: Iv0, b: Iv1, c: Iv2, d: Iv3, e: Iv4};
  end
  assign vld[0] = in_valid;

  for (genvar s = 0; s < NumSteps; s++) begin : g_step
    rmd160_step u_step (
      .clk      (clk),
      .rst      (rst),
      .step_idx (7'(s)),
      .adv      (adv),
      .in_valid (vld[s]),
      .in_data  (dat[s]),
      .out_valid(vld[s+1]),
      .out_data (dat[s+1])
    );
  end

  // Final cross-addition of the two lines with the initial values.
  assign fin = dat[NumSteps];
  assign h0 = Iv1 + fin.lft.c + fin.rgt.d;
  assign h1 = Iv2 + fin.lft.d + fin.rgt.e;
  assign h2 = Iv3 + fin.lft.e + fin.rgt.a;
  assign h3 = Iv4 + fin.lft.a + fin.rgt.b;
  assign h4 = Iv0 + fin.lft.b + fin.rgt.c;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[NumSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.digest_bytes_0_7   <= {h1, h0};
      out_data.digest_bytes_8_15  <= {h3, h2};
      out_data.digest_bytes_16_19 <= h4;
    end
  end

endmodule
